### rtl/multi_slot_animation_frame_timer_assert.svh
// Assertion macros shared by the animation frame timer RTL.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef MULTI_SLOT_ANIMATION_FRAME_TIMER_ASSERT_SVH
`define MULTI_SLOT_ANIMATION_FRAME_TIMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// cond holds on every clock edge outside reset
`define MFAT_ASSERT_HOLD(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// cons holds in the cycle after ante
`define MFAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MFAT_ASSERT_HOLD(label, clk, rst, cond, msg)
`define MFAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/mfat_pkg.sv
`timescale 1ns / 1ps
// Package of the animation frame timer: codes, command and status types.
// Used by every module of the block but mfat_ram; depends on nothing.
package mfat_pkg;

   localparam int unsigned SLOTS_DEFAULT      = 16;
   localparam int unsigned MAX_FRAMES_DEFAULT = 64;
   localparam int unsigned CMD_QUEUE_DEPTH    = 2;
   localparam int unsigned US_PER_MS          = 1000;
   localparam int unsigned NEED_W             = 26;   // 65535 * 1000 fits

   // action codes on req_tuser
   localparam logic [1:0] ACT_TICK        = 2'd0;
   localparam logic [1:0] ACT_WRITE_DELAY = 2'd1;
   localparam logic [1:0] ACT_START       = 2'd2;
   localparam logic [1:0] ACT_CLEAR       = 2'd3;

   // register indexes on csr_index
   localparam logic [2:0] CSR_LOOP_ENABLED = 3'd0;
   localparam logic [2:0] CSR_BG_X         = 3'd1;
   localparam logic [2:0] CSR_BG_Y         = 3'd2;
   localparam logic [2:0] CSR_ANIM_W       = 3'd3;
   localparam logic [2:0] CSR_ANIM_H       = 3'd4;
   localparam logic [2:0] CSR_LAYER_W      = 3'd5;
   localparam logic [2:0] CSR_LAYER_H      = 3'd6;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_WRITE_DELAY,
      CMD_SET_SLOT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   slot;
      logic [5:0]   frame;
      logic [15:0]  delay_ms;
      logic [6:0]   frame_count;
      logic [23:0]  elapsed_us;
   } cmd_type;

   typedef struct packed {
      logic [11:0] bg_x;
      logic [11:0] bg_y;
      logic [11:0] anim_w;
      logic [11:0] anim_h;
      logic [11:0] layer_w;
      logic [11:0] layer_h;
   } bounds_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_WALK,
      ENG_DRAIN
   } eng_state_type;

   typedef struct packed {
      logic idle;
      logic tick_active;
   } eng_status_type;

endpackage

### rtl/multi_slot_animation_frame_timer.sv
// Top level of the multi-slot animation frame timer: config registers,
// front end, command queue and engine. Uses mfat_pkg and the assert header.
//
//   channel   dir  handshake          payload
//   req_*     in   tvalid/tready      tuser: action; tdata: slot, frame,
//                                     delay_ms, frame_count, elapsed_us
//   rsp_*     out  tvalid/tready      tdata: out_slot, frame_index;
//                                     tuser: drawn; tlast: last
//   csr_*     in   we (no wait)       index 0..6, 12-bit data
//
// A tick walks the slots, then drains the pipeline and dispatches the last result.
// The engine visits one slot per cycle unless the result output holds the walk, set
// by the single read port of the delay RAM. Load items apply as the engine pops them.
// Reset is synchronous: it clears config, slot timers and queue; the delay
// RAM is not cleared and holds garbage until written.
// A stalled result output freezes the slot walk; the queue takes items until full.
`timescale 1ns / 1ps
`include "multi_slot_animation_frame_timer_assert.svh"
module multi_slot_animation_frame_timer #(
   parameter int unsigned SLOTS      = mfat_pkg::SLOTS_DEFAULT,
   parameter int unsigned MAX_FRAMES = mfat_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] slot, [9:4] frame, [25:10] delay_ms, [32:26] frame_count,
   // [56:33] elapsed_us, [63:57] zero
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] out_slot, [9:4] frame_index, [15:10] zero
   output logic        rsp_tuser,   // [0] drawn
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   logic                     loop_enabled_ff;
   mfat_pkg::bounds_type     bounds_ff;

   logic                     q_push, q_ready, q_pop, q_valid;
   mfat_pkg::cmd_type        push_cmd, q_cmd;
   mfat_pkg::eng_status_type eng_stat;

   // config registers; written only while the block is idle: a rule for the user that the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_enabled_ff <= 1'b0;
         bounds_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            mfat_pkg::CSR_LOOP_ENABLED: loop_enabled_ff   <= csr_wdata[0];
            mfat_pkg::CSR_BG_X:         bounds_ff.bg_x    <= csr_wdata;
            mfat_pkg::CSR_BG_Y:         bounds_ff.bg_y    <= csr_wdata;
            mfat_pkg::CSR_ANIM_W:       bounds_ff.anim_w  <= csr_wdata;
            mfat_pkg::CSR_ANIM_H:       bounds_ff.anim_h  <= csr_wdata;
            mfat_pkg::CSR_LAYER_W:      bounds_ff.layer_w <= csr_wdata;
            mfat_pkg::CSR_LAYER_H:      bounds_ff.layer_h <= csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // classify: drop ignored items here so they never reach the engine
   mfat_front #(
      .SLOTS      (SLOTS),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .loop_enabled (loop_enabled_ff),
      .q_ready      (q_ready),
      .q_push       (q_push),
      .q_cmd        (push_cmd)
   );

   mfat_fifo #(
      .DEPTH (mfat_pkg::CMD_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_cmd    (q_cmd),
      .pop_valid  (q_valid)
   );

   // engine: slot walk pipeline, delay RAM and result register
   mfat_back #(
      .SLOTS      (SLOTS),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .bounds     (bounds_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .status     (eng_stat)
   );

   // the engine takes a command only between ticks
   `MFAT_ASSERT_HOLD(a_pop_when_idle, clock, reset, !q_pop || eng_stat.idle, "pop while busy")
   // a dequeued tick starts a slot walk on the next cycle
   `MFAT_ASSERT_NEXT(a_tick_starts_walk, clock, reset, q_pop && q_cmd.kind == mfat_pkg::CMD_TICK, eng_stat.tick_active, "tick not started")
   // only the background can be suppressed by bounds
   `MFAT_ASSERT_HOLD(a_undrawn_is_bg, clock, reset, !(rsp_tvalid && !rsp_tuser) || rsp_tdata[3:0] == 4'd0, "undrawn key result")
endmodule

### rtl/mfat_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module mfat_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/mfat_front.sv
`timescale 1ns / 1ps
// Front end: unpack and classify input items into engine commands.
// Uses mfat_pkg for action codes and the command type.
module mfat_front #(
   parameter int unsigned SLOTS      = mfat_pkg::SLOTS_DEFAULT,
   parameter int unsigned MAX_FRAMES = mfat_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   input  logic              loop_enabled,
   input  logic              q_ready,
   output logic              q_push,
   output mfat_pkg::cmd_type q_cmd
);
   logic slot_ok;
   logic frame_ok;
   logic keep;

   assign slot_ok  = 32'(req_tdata[3:0]) < SLOTS;
   assign frame_ok = 32'(req_tdata[9:4]) < MAX_FRAMES;

   always_comb begin
      keep              = 1'b0;
      q_cmd.kind        = mfat_pkg::CMD_TICK;
      q_cmd.slot        = req_tdata[3:0];
      q_cmd.frame       = req_tdata[9:4];
      q_cmd.delay_ms    = req_tdata[25:10];
      q_cmd.frame_count = req_tdata[32:26];
      q_cmd.elapsed_us  = req_tdata[56:33];
      unique case (req_tuser)
         mfat_pkg::ACT_TICK: begin
            // drop ticks while looping is off
            keep = loop_enabled;
         end
         mfat_pkg::ACT_WRITE_DELAY: begin
            keep       = slot_ok && frame_ok;
            q_cmd.kind = mfat_pkg::CMD_WRITE_DELAY;
         end
         mfat_pkg::ACT_START: begin
            keep       = slot_ok;
            q_cmd.kind = mfat_pkg::CMD_SET_SLOT;
         end
         mfat_pkg::ACT_CLEAR: begin
            keep              = slot_ok;
            q_cmd.kind        = mfat_pkg::CMD_SET_SLOT;
            q_cmd.frame_count = '0;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready && keep;
endmodule

### rtl/mfat_fifo.sv
`timescale 1ns / 1ps
// Short command queue between front end and engine.
// Uses mfat_pkg for the command type.
module mfat_fifo #(
   parameter int unsigned DEPTH = mfat_pkg::CMD_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mfat_pkg::cmd_type push_cmd,
   output logic              push_ready,
   input  logic              pop,
   output mfat_pkg::cmd_type pop_cmd,
   output logic              pop_valid
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   mfat_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

### rtl/mfat_back.sv
`timescale 1ns / 1ps
// Engine: applies load commands and walks the slots on each tick.
// Uses mfat_pkg and instantiates mfat_ram for the delay table.
module mfat_back #(
   parameter int unsigned SLOTS      = mfat_pkg::SLOTS_DEFAULT,
   parameter int unsigned MAX_FRAMES = mfat_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  mfat_pkg::cmd_type        q_cmd,
   output logic                     q_pop,
   input  mfat_pkg::bounds_type     bounds,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast,
   output mfat_pkg::eng_status_type status
);
   localparam int unsigned SLOT_W    = $clog2(SLOTS);
   localparam int unsigned FR_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int unsigned FC_W      = $clog2(MAX_FRAMES + 1);
   localparam int unsigned CMP_W     = FC_W + 1;
   localparam int unsigned RAM_DEPTH = SLOTS * (2 ** FR_W);
   localparam int unsigned NW        = mfat_pkg::NEED_W;

   mfat_pkg::eng_state_type state_ff, state_in;

   logic [SLOT_W-1:0] walk_slot_ff, walk_slot_in;
   logic [23:0]       elapsed_ff, elapsed_in;

   // per-slot timer state
   logic [FC_W-1:0]   fc_ff  [SLOTS];
   logic [FR_W-1:0]   cur_ff [SLOTS];
   logic [31:0]       acc_ff [SLOTS];

   // stage 1: slot read, delay RAM read in flight
   logic              p1_valid_ff;
   logic [SLOT_W-1:0] p1_slot_ff;
   logic [FC_W-1:0]   p1_fc_ff;
   logic [FR_W-1:0]   p1_cur_ff;
   // stage 2: accumulated sum and threshold
   logic              p2_valid_ff;
   logic [SLOT_W-1:0] p2_slot_ff;
   logic [FC_W-1:0]   p2_fc_ff;
   logic [FR_W-1:0]   p2_cur_ff;
   logic [31:0]       p2_sum_ff;
   logic [NW-1:0]     p2_need_ff;
   // one result held back until the next one shows whether it is the last
   logic              pend_valid_ff;
   logic [3:0]        pend_slot_ff;
   logic [5:0]        pend_frame_ff;
   logic              pend_drawn_ff;
   // output register
   logic              rsp_valid_ff;
   logic [3:0]        rsp_slot_ff;
   logic [5:0]        rsp_frame_ff;
   logic              rsp_drawn_ff;
   logic              rsp_last_ff;

   logic              out_free, adv, hit, issue, drained;
   logic              push_mid, push_end;
   logic              set_slot, write_delay;
   logic [FC_W-1:0]   fc_rd;
   logic [FR_W-1:0]   cur_rd, cur_norm, next_cur;
   logic [32:0]       sum_wide;
   logic [31:0]       sum_sat;
   logic [15:0]       delay_rd;
   logic [NW-1:0]     need;
   logic              bounds_ok, drawn;
   logic [FC_W-1:0]   set_count;
   logic [SLOT_W-1:0] cmd_slot;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign hit      = p2_valid_ff && (p2_sum_ff >= 32'(p2_need_ff));
   assign adv      = !(hit && pend_valid_ff && !out_free);
   assign drained  = !p1_valid_ff && !p2_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfat_pkg::ENG_IDLE: begin
            if (q_valid && q_cmd.kind == mfat_pkg::CMD_TICK) begin
               state_in = mfat_pkg::ENG_WALK;
            end
         end
         mfat_pkg::ENG_WALK: begin
            if (adv && walk_slot_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = mfat_pkg::ENG_DRAIN;
            end
         end
         mfat_pkg::ENG_DRAIN: begin
            if (drained && (!pend_valid_ff || out_free)) begin
               state_in = mfat_pkg::ENG_IDLE;
            end
         end
         default: state_in = mfat_pkg::ENG_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop              = 1'b0;
      issue              = 1'b0;
      push_end           = 1'b0;
      status.idle        = 1'b0;
      status.tick_active = 1'b1;
      unique case (state_ff)
         mfat_pkg::ENG_IDLE: begin
            q_pop              = q_valid;
            status.idle        = 1'b1;
            status.tick_active = 1'b0;
         end
         mfat_pkg::ENG_WALK: begin
            issue = adv;
         end
         mfat_pkg::ENG_DRAIN: begin
            push_end = drained && pend_valid_ff && out_free;
         end
         default: begin
            status.idle        = 1'b1;
            status.tick_active = 1'b0;
         end
      endcase
   end

   assign set_slot    = q_pop && q_cmd.kind == mfat_pkg::CMD_SET_SLOT;
   assign write_delay = q_pop && q_cmd.kind == mfat_pkg::CMD_WRITE_DELAY;
   assign cmd_slot    = SLOT_W'(q_cmd.slot);
   assign set_count   = (32'(q_cmd.frame_count) > MAX_FRAMES) ?
                        FC_W'(MAX_FRAMES) : FC_W'(q_cmd.frame_count);

   always_comb begin
      walk_slot_in = walk_slot_ff;
      elapsed_in   = elapsed_ff;
      if (q_pop && q_cmd.kind == mfat_pkg::CMD_TICK) begin
         walk_slot_in = '0;
         elapsed_in   = q_cmd.elapsed_us;
      end else if (issue) begin
         walk_slot_in = walk_slot_ff + 1'b1;
      end
   end

   // stage 0: read slot state, normalize the frame, address the delay
   assign fc_rd    = fc_ff[walk_slot_ff];
   assign cur_rd   = cur_ff[walk_slot_ff];
   assign cur_norm = (CMP_W'(cur_rd) >= CMP_W'(fc_rd)) ? '0 : cur_rd;

   mfat_ram #(
      .WIDTH (16),
      .DEPTH (RAM_DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (write_delay),
      .wr_addr ({cmd_slot, FR_W'(q_cmd.frame)}),
      .wr_data (q_cmd.delay_ms),
      .rd_en   (adv),
      .rd_addr ({walk_slot_ff, cur_norm}),
      .rd_data (delay_rd)
   );

   // stage 1: saturating add and threshold
   assign sum_wide = {1'b0, acc_ff[p1_slot_ff]} + 33'(elapsed_ff);
   assign sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
   assign need     = NW'(delay_rd) * NW'(mfat_pkg::US_PER_MS);

   // stage 2: advance on a hit
   assign next_cur  = (CMP_W'(p2_cur_ff) + 1'b1 >= CMP_W'(p2_fc_ff)) ?
                      '0 : FR_W'(CMP_W'(p2_cur_ff) + 1'b1);
   assign bounds_ok = (13'(bounds.bg_x) + 13'(bounds.anim_w) <= 13'(bounds.layer_w)) &&
                      (13'(bounds.bg_y) + 13'(bounds.anim_h) <= 13'(bounds.layer_h));
   assign drawn     = (p2_slot_ff == '0) ? bounds_ok : 1'b1;
   assign push_mid  = adv && hit && pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mfat_pkg::ENG_IDLE;
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            fc_ff[i]  <= '0;
            cur_ff[i] <= '0;
            acc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (adv) begin
            p1_valid_ff <= issue && (fc_rd != '0);
            p2_valid_ff <= p1_valid_ff;
         end
         if (set_slot) begin
            fc_ff[cmd_slot]  <= set_count;
            cur_ff[cmd_slot] <= '0;
            acc_ff[cmd_slot] <= '0;
         end else if (adv && p2_valid_ff) begin
            acc_ff[p2_slot_ff] <= hit ? p2_sum_ff - 32'(p2_need_ff) : p2_sum_ff;
            if (hit) begin
               cur_ff[p2_slot_ff] <= next_cur;
            end
         end
         if (adv && hit) begin
            pend_valid_ff <= 1'b1;
         end else if (push_end) begin
            pend_valid_ff <= 1'b0;
         end
         if (push_mid || push_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      walk_slot_ff <= walk_slot_in;
      elapsed_ff   <= elapsed_in;
      if (adv) begin
         p1_slot_ff <= walk_slot_ff;
         p1_fc_ff   <= fc_rd;
         p1_cur_ff  <= cur_norm;
         p2_slot_ff <= p1_slot_ff;
         p2_fc_ff   <= p1_fc_ff;
         p2_cur_ff  <= p1_cur_ff;
         p2_sum_ff  <= sum_sat;
         p2_need_ff <= need;
      end
      if (adv && hit) begin
         pend_slot_ff  <= 4'(p2_slot_ff);
         pend_frame_ff <= 6'(next_cur);
         pend_drawn_ff <= drawn;
      end
      if (push_mid || push_end) begin
         rsp_slot_ff  <= pend_slot_ff;
         rsp_frame_ff <= pend_frame_ff;
         rsp_drawn_ff <= pend_drawn_ff;
         rsp_last_ff  <= push_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_frame_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_drawn_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

### bench/frame_event_checker.sv
`timescale 1ns / 1ps
// Frame event checker: keeps its own copy of the slot timers, predicts the
// frame events of every accepted item and compares them with the result stream.
// Depends on mfat_pkg for the action and register codes.
module frame_event_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata,
   output int unsigned fail_count,
   output int unsigned pending_count
);
   localparam int unsigned N_SLOTS  = mfat_pkg::SLOTS_DEFAULT;
   localparam int unsigned N_FRAMES = mfat_pkg::MAX_FRAMES_DEFAULT;
   localparam int unsigned MAX_PRINTS = 100;

   typedef struct packed {
      logic [3:0] slot;
      logic [5:0] frame;
      logic       drawn;
      logic       last;
   } frame_event_type;

   // predicted block state
   logic [15:0] delay_ms_tbl [N_SLOTS][N_FRAMES];
   logic [6:0]  run_frames [N_SLOTS];
   logic [5:0]  cur_frame [N_SLOTS];
   logic [31:0] acc_us [N_SLOTS];
   logic        loop_on;
   logic [11:0] bg_x, bg_y, anim_w, anim_h, layer_w, layer_h;

   frame_event_type frame_events_due [$];

   task automatic report_mismatch(input string what);
      if (fail_count < MAX_PRINTS) $display("[%0t] frame event mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string field, input int unsigned slot,
                              input int unsigned got_v, input int unsigned want_v);
      if (got_v != want_v)
         report_mismatch($sformatf("%s of slot %0d event: got %0d, want %0d",
                                   field, slot, got_v, want_v));
   endtask

   // Walk the slots in ascending order; mark the last event of the tick.
   task automatic advance_timers(input logic [23:0] elapsed);
      logic [32:0]     sum;
      logic [31:0]     need;
      logic [6:0]      cur;
      logic            fits;
      frame_event_type held;
      bit              have_held;
      have_held = 0;
      held = '0;
      fits = ({1'b0, bg_x} + {1'b0, anim_w} <= {1'b0, layer_w}) &&
             ({1'b0, bg_y} + {1'b0, anim_h} <= {1'b0, layer_h});
      for (int s = 0; s < N_SLOTS; s++) begin
         if (run_frames[s] != 0) begin
            cur = {1'b0, cur_frame[s]};
            if (cur >= run_frames[s]) cur = '0;
            sum = {1'b0, acc_us[s]} + {9'd0, elapsed};
            acc_us[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            need = 32'(delay_ms_tbl[s][cur[5:0]]) * mfat_pkg::US_PER_MS;
            if (acc_us[s] >= need) begin
               acc_us[s] = acc_us[s] - need;
               cur = cur + 7'd1;
               if (cur >= run_frames[s]) cur = '0;
               cur_frame[s] = cur[5:0];
               if (have_held) frame_events_due.insert(frame_events_due.size(), held);
               held.slot  = s[3:0];
               held.frame = cur[5:0];
               held.drawn = (s != 0) || fits;
               held.last  = 1'b0;
               have_held  = 1;
            end
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         frame_events_due.insert(frame_events_due.size(), held);
      end
   endtask

   task automatic apply_item(input logic [1:0] action, input logic [63:0] data);
      logic [3:0]  slot;
      logic [5:0]  frame;
      logic [15:0] delay_ms;
      logic [6:0]  count;
      slot     = data[3:0];
      frame    = data[9:4];
      delay_ms = data[25:10];
      count    = data[32:26];
      case (action)
         mfat_pkg::ACT_WRITE_DELAY: delay_ms_tbl[slot][frame] = delay_ms;
         mfat_pkg::ACT_START, mfat_pkg::ACT_CLEAR: begin
            if (action == mfat_pkg::ACT_CLEAR) count = '0;
            else if (count > N_FRAMES) count = 7'(N_FRAMES);
            run_frames[slot] = count;
            cur_frame[slot]  = '0;
            acc_us[slot]     = '0;
         end
         default: if (loop_on) advance_timers(data[56:33]);
      endcase
   endtask

   always @(posedge clock) begin : watch
      frame_event_type want;
      if (reset) begin
         for (int s = 0; s < N_SLOTS; s++) begin
            run_frames[s] = '0;
            cur_frame[s]  = '0;
            acc_us[s]     = '0;
         end
         loop_on = 1'b0;
         bg_x = '0; bg_y = '0; anim_w = '0; anim_h = '0; layer_w = '0; layer_h = '0;
         frame_events_due.delete();
      end else begin
         // results first: a result at this edge never belongs to an item taken at it
         if (rsp_tvalid && rsp_tready) begin
            if (frame_events_due.size() == 0) begin
               report_mismatch($sformatf("unexpected event slot %0d frame %0d",
                                         rsp_tdata[3:0], rsp_tdata[9:4]));
            end else begin
               want = frame_events_due.pop_front();
               check_field("out_slot", want.slot, rsp_tdata[3:0], want.slot);
               check_field("frame_index", want.slot, rsp_tdata[9:4], want.frame);
               check_field("drawn", want.slot, rsp_tuser, want.drawn);
               check_field("last", want.slot, rsp_tlast, want.last);
            end
         end
         if (csr_we) begin
            case (csr_index)
               mfat_pkg::CSR_LOOP_ENABLED: loop_on = csr_wdata[0];
               mfat_pkg::CSR_BG_X:         bg_x    = csr_wdata;
               mfat_pkg::CSR_BG_Y:         bg_y    = csr_wdata;
               mfat_pkg::CSR_ANIM_W:       anim_w  = csr_wdata;
               mfat_pkg::CSR_ANIM_H:       anim_h  = csr_wdata;
               mfat_pkg::CSR_LAYER_W:      layer_w = csr_wdata;
               mfat_pkg::CSR_LAYER_H:      layer_h = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) apply_item(req_tuser, req_tdata);
      end
      pending_count <= frame_events_due.size();
   end

endmodule

### bench/multi_slot_animation_frame_timer_tb.sv
`timescale 1ns / 1ps
// Top of the animation frame timer bench: clock, reset, item and register
// stimulus, result back-pressure and verdict. Needs mfat_pkg and frame_event_checker.
module multi_slot_animation_frame_timer_tb;

   // Quiet time before a register write: ticks that raise no event may still
   // sit in the two-deep command queue and the engine.
   localparam int unsigned IDLE_WAIT = 64;

   typedef enum logic [1:0] {
      RDY_OPEN,      // take every event
      RDY_MOSTLY,    // stall one cycle in four
      RDY_SPARSE,    // take one cycle in eight
      RDY_TOGGLE     // alternate
   } ready_pattern_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [63:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = mfat_pkg::ACT_TICK;
   logic        rsp_tready = 1'b0;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = mfat_pkg::CSR_LOOP_ENABLED;
   logic [11:0] csr_wdata  = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int unsigned fail_count;
   int unsigned pending_count;

   // Delay entries written so far. A running slot moves at most one frame per
   // tick, so before each tick the furthest frame it can reach gets a delay;
   // the walk never reads an entry the block has not been given.
   bit          delay_set   [mfat_pkg::SLOTS_DEFAULT][mfat_pkg::MAX_FRAMES_DEFAULT];
   int unsigned span_of     [mfat_pkg::SLOTS_DEFAULT];
   int unsigned ticks_since [mfat_pkg::SLOTS_DEFAULT];

   int unsigned       burst_left = 0;
   ready_pattern_type ready_mode = RDY_OPEN;
   int unsigned       mode_left  = 0;

   multi_slot_animation_frame_timer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   frame_event_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // Result back-pressure: hold one pattern for a random stretch, then switch.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_pattern_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(10, 150);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         RDY_OPEN:   rsp_tready <= 1'b1;
         RDY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
         RDY_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
         default:    rsp_tready <= ~rsp_tready;
      endcase
   end

   // Send one item. Items go out in bursts, now and then a long one; before each new
   // burst open a gap, now and then a long one, and sometimes none at all.
   // Enter and leave on a rising edge; leave at the edge that took the item.
   task automatic send_item(input logic [1:0] action, input logic [3:0] slot,
                            input logic [5:0] frame, input logic [15:0] delay_ms,
                            input logic [6:0] count, input logic [23:0] elapsed);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {7'd0, elapsed, count, delay_ms, frame, slot};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [15:0] pick_delay();
      // mostly a few milliseconds so frames turn over often
      return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
   endfunction

   function automatic logic [23:0] pick_elapsed();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 24'hFF_FFFF;
         2:       return 24'($urandom);
         default: return 24'($urandom_range(0, 15000));
      endcase
   endfunction

   function automatic logic [6:0] pick_count();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return 7'($urandom_range(64, 127));
         default: return 7'($urandom_range(1, 6));
      endcase
   endfunction

   // Fields that the action does not use carry noise.
   task automatic put_delay(input int unsigned slot, input int unsigned frame,
                            input logic [15:0] delay_ms);
      send_item(mfat_pkg::ACT_WRITE_DELAY, slot[3:0], frame[5:0], delay_ms, 7'($urandom),
                24'($urandom));
      delay_set[slot][frame] = 1;
   endtask

   // Give frame 0 a delay if it has none, then start the slot.
   task automatic start_slot(input int unsigned slot, input logic [6:0] count);
      int unsigned span;
      span = (count > mfat_pkg::MAX_FRAMES_DEFAULT) ? mfat_pkg::MAX_FRAMES_DEFAULT : count;
      if (span != 0 && !delay_set[slot][0]) put_delay(slot, 0, pick_delay());
      send_item(mfat_pkg::ACT_START, slot[3:0], 6'($urandom), 16'($urandom), count,
                24'($urandom));
      span_of[slot]     = span;
      ticks_since[slot] = 0;
   endtask

   // A nonzero count rides along; clear must drop it.
   task automatic clear_slot(input int unsigned slot);
      send_item(mfat_pkg::ACT_CLEAR, slot[3:0], 6'($urandom), 16'($urandom),
                7'($urandom_range(1, 127)), 24'($urandom));
      span_of[slot] = 0;
   endtask

   // Fill in the furthest frame each running slot can reach, then tick.
   task automatic tick(input logic [23:0] elapsed);
      int unsigned f;
      for (int s = 0; s < mfat_pkg::SLOTS_DEFAULT; s++) begin
         if (span_of[s] != 0) begin
            f = (ticks_since[s] < span_of[s]) ? ticks_since[s] : span_of[s] - 1;
            if (!delay_set[s][f]) put_delay(s, f, pick_delay());
         end
      end
      send_item(mfat_pkg::ACT_TICK, 4'($urandom), 6'($urandom), 16'($urandom),
                7'($urandom), elapsed);
      for (int s = 0; s < mfat_pkg::SLOTS_DEFAULT; s++)
         if (span_of[s] != 0) ticks_since[s]++;
   endtask

   // Drop valid, let every predicted event drain, then give the queue time.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic put_reg(input logic [2:0] index, input logic [11:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write all seven registers back to back. Upper bits of the loop register
   // carry noise; only bit 0 counts.
   task automatic program_regs(input logic loop_on, input logic [11:0] bx, aw, lw,
                               input logic [11:0] by, ah, lh);
      put_reg(mfat_pkg::CSR_LOOP_ENABLED, {11'($urandom), loop_on});
      put_reg(mfat_pkg::CSR_BG_X, bx);
      put_reg(mfat_pkg::CSR_BG_Y, by);
      put_reg(mfat_pkg::CSR_ANIM_W, aw);
      put_reg(mfat_pkg::CSR_ANIM_H, ah);
      put_reg(mfat_pkg::CSR_LAYER_W, lw);
      put_reg(mfat_pkg::CSR_LAYER_H, lh);
      csr_we <= 1'b0;
   endtask

   // Random placement; two times in three the background fits along an axis.
   task automatic random_regs();
      logic [11:0] lw, lh, aw, ah, bx, by;
      lw = 12'($urandom);
      lh = 12'($urandom);
      aw = 12'($urandom);
      ah = 12'($urandom);
      bx = 12'($urandom);
      by = 12'($urandom);
      if ($urandom_range(0, 2) != 0) begin
         aw = 12'($urandom_range(0, lw));
         bx = 12'($urandom_range(0, lw - aw));
      end
      if ($urandom_range(0, 2) != 0) begin
         ah = 12'($urandom_range(0, lh));
         by = 12'($urandom_range(0, lh - ah));
      end
      program_regs($urandom_range(0, 7) != 0, bx, aw, lw, by, ah, lh);
   endtask

   // One tick with the background active under the given placement.
   task automatic bounds_case(input logic [11:0] bx, aw, lw, input logic [11:0] by, ah, lh);
      wait_idle();
      program_regs(1'b1, bx, aw, lw, by, ah, lh);
      tick(pick_elapsed());
   endtask

   task automatic random_item();
      int unsigned pick;
      int unsigned slot;
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, mfat_pkg::SLOTS_DEFAULT - 1);
      if (pick < 45)
         tick(pick_elapsed());
      else if (pick < 65)
         put_delay(slot, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 7), pick_delay());
      else if (pick < 90)
         start_slot(slot, pick_count());
      else
         clear_slot(slot);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Loop is off after reset: a tick must change nothing.
      put_delay(0, 0, 16'd0);
      put_delay(0, 1, 16'd3);
      start_slot(0, 7'd2);
      tick(24'hFF_FFFF);

      // Loop on, all bounds zero: the background still fits.
      wait_idle();
      program_regs(1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
      tick(24'd0);          // zero delay turns frame 0 over at once
      tick(24'd2999);       // one microsecond short of 3 ms
      tick(24'd1);          // reach it and wrap back to frame 0
      start_slot(15, 7'd127);   // oversized count saturates to 64 frames
      start_slot(7, 7'd1);
      start_slot(2, 7'd0);      // zero count leaves the slot idle
      tick(24'hFF_FFFF);
      put_delay(7, 0, 16'hFFFF);  // rewrite the delay of a running slot
      tick(24'hFF_FFFF);
      clear_slot(15);

      // Every slot on zero delay: one tick yields the full set of events.
      for (int s = 0; s < mfat_pkg::SLOTS_DEFAULT; s++) begin
         put_delay(s, 0, 16'd0);
         start_slot(s, 7'd1);
      end
      tick(24'($urandom));

      // Placement: exact fit, one pixel over in x, one over in y, all at max.
      bounds_case(12'd100, 12'd200, 12'd300, 12'd50, 12'd60, 12'd110);
      bounds_case(12'd101, 12'd200, 12'd300, 12'd50, 12'd60, 12'd110);
      bounds_case(12'd100, 12'd200, 12'd300, 12'd51, 12'd60, 12'd110);
      bounds_case(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);

      // Random traffic in phases, with a fresh register setting before each.
      repeat (3) begin
         wait_idle();
         random_regs();
         repeat (20) random_item();
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
